// File: rtl/tops_pkg.sv
package tops_pkg;

  localparam int MAX_KINDS      = 10;
  localparam int MAX_AREA_BYTES = 40;

  // only the first four listed kinds feed the outputs and the verdict
  localparam int KEEP_KINDS = 4;
  localparam int KIDX_W     = $clog2(KEEP_KINDS);
  localparam int CNT_W      = $clog2(MAX_KINDS + 1);
  localparam int AREA_W     = $clog2(MAX_AREA_BYTES + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] KIND_END  = 8'd0;
  localparam logic [7:0] KIND_NOP  = 8'd1;
  localparam logic [7:0] KIND_MSS  = 8'd2;
  localparam logic [7:0] KIND_WS   = 8'd3;
  localparam logic [7:0] KIND_SACK = 8'd4;
  localparam logic [7:0] KIND_TS   = 8'd8;

  localparam int FL_MSS  = 0;
  localparam int FL_WS   = 1;
  localparam int FL_SACK = 2;
  localparam int FL_TS   = 3;
  localparam int FL_NOP  = 4;
  localparam int FL_W    = 5;

  typedef enum logic [1:0] {
    VERDICT_NONE     = 2'd0,
    VERDICT_MSS_NOP  = 2'd1,
    VERDICT_MSS_SACK = 2'd2
  } verdict_t;

  // one classified request as it waits in the queue
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
    logic       is_end;
    logic       is_nop;
    logic       is_two;
  } item_t;

  typedef struct packed {
    logic              head_valid;
    logic [QCNT_W-1:0] count;
    logic              push;
  } queue_status_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [3:0]  option_count;
    logic        has_mss;
    logic [15:0] mss_size;
    logic        has_wscale;
    logic [7:0]  wscale_value;
    logic        has_sack_perm;
    logic        has_timestamp;
    logic        has_noop;
    logic [7:0]  first_kind;
    logic [7:0]  second_kind;
    logic [7:0]  third_kind;
  } result_t;

endpackage

// File: rtl/tops_front.sv
module tops_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             opt_byte,
  input  logic                   byte_valid,
  input  logic                   last_byte,
  input  logic                   pop,
  output tops_pkg::item_t        head,
  output tops_pkg::queue_status_t status
);

  tops_pkg::item_t             entries [tops_pkg::QUEUE_DEPTH];
  logic [tops_pkg::QPTR_W-1:0] wr_ptr;
  logic [tops_pkg::QPTR_W-1:0] rd_ptr;
  logic [tops_pkg::QCNT_W-1:0] count;
  tops_pkg::item_t             item;
  logic                        push;
  logic                        do_pop;

  always_comb begin
    item.data     = opt_byte;
    item.has_byte = byte_valid;
    item.last     = last_byte;
    item.is_end   = (opt_byte == tops_pkg::KIND_END);
    item.is_nop   = (opt_byte == tops_pkg::KIND_NOP);
    item.is_two   = (opt_byte == 8'd2);
  end

  assign in_ready = (count != tops_pkg::QCNT_W'(tops_pkg::QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign do_pop   = pop && (count != '0);
  assign head     = entries[rd_ptr];

  assign status.head_valid = (count != '0);
  assign status.count      = count;
  assign status.push       = push;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/tops_back.sv
module tops_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  tops_pkg::item_t   head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output tops_pkg::result_t result
);

  typedef enum logic [1:0] {
    PH_KIND,
    PH_LEN,
    PH_BODY
  } phase_t;

  phase_t                      phase, phase_next;
  logic                        stopped, stopped_next;
  logic [7:0]                  cur_kind, cur_kind_next;
  logic [7:0]                  rec_len, rec_len_next;
  logic [7:0]                  body_pos, body_pos_next;
  logic [15:0]                 pend, pend_next;
  logic [15:0]                 seg, seg_next;
  logic [7:0]                  scale, scale_next;
  logic [tops_pkg::FL_W-1:0]   flags, flags_next;
  logic [7:0]                  kinds [tops_pkg::KEEP_KINDS];
  logic [7:0]                  kinds_next [tops_pkg::KEEP_KINDS];
  logic [tops_pkg::CNT_W-1:0]  count, count_next;
  logic [tops_pkg::AREA_W-1:0] area, area_next;
  logic                        commit;
  logic                        list_it;
  logic [7:0]                  list_kind;
  logic                        out_free;
  tops_pkg::verdict_t          verdict;
  tops_pkg::result_t           res_next;

  assign out_free = !out_valid || out_ready;
  assign pop      = head_valid && (!head.last || out_free);

  always_comb begin
    phase_next    = phase;
    stopped_next  = stopped;
    cur_kind_next = cur_kind;
    rec_len_next  = rec_len;
    body_pos_next = body_pos;
    pend_next     = pend;
    seg_next      = seg;
    scale_next    = scale;
    flags_next    = flags;
    kinds_next    = kinds;
    count_next    = count;
    area_next     = area;
    commit        = 1'b0;
    list_it       = 1'b0;
    list_kind     = cur_kind;

    if (head.has_byte && !stopped && area < tops_pkg::AREA_W'(tops_pkg::MAX_AREA_BYTES)) begin
      area_next = area + 1'b1;
      unique case (phase)
        PH_KIND: begin
          if (head.is_end) begin
            stopped_next = 1'b1;
          end else if (head.is_nop) begin
            flags_next[tops_pkg::FL_NOP] = 1'b1;
            list_it   = 1'b1;
            list_kind = tops_pkg::KIND_NOP;
          end else begin
            cur_kind_next = head.data;
            phase_next    = PH_LEN;
          end
        end
        PH_LEN: begin
          rec_len_next  = head.data;
          pend_next     = '0;
          body_pos_next = '0;
          if (head.is_end || head.is_nop) begin
            stopped_next = 1'b1;
            phase_next   = PH_KIND;
          end else if (head.is_two) begin
            commit = 1'b1;
          end else begin
            phase_next = PH_BODY;
          end
        end
        PH_BODY: begin
          if (body_pos == 8'd0) begin
            pend_next = {head.data, 8'h00};
          end else if (body_pos == 8'd1) begin
            pend_next = {pend[15:8], head.data};
          end
          body_pos_next = body_pos + 8'd1;
          // record done once kind, length and body bytes add up to its length
          if ({1'b0, body_pos} + 9'd3 >= {1'b0, rec_len}) begin
            commit = 1'b1;
          end
        end
        default: phase_next = PH_KIND;
      endcase
    end

    if (commit) begin
      case (cur_kind)
        tops_pkg::KIND_MSS: begin
          flags_next[tops_pkg::FL_MSS] = 1'b1;
          seg_next = pend_next;
        end
        tops_pkg::KIND_WS: begin
          flags_next[tops_pkg::FL_WS] = 1'b1;
          scale_next = pend_next[15:8];
        end
        tops_pkg::KIND_SACK: flags_next[tops_pkg::FL_SACK] = 1'b1;
        tops_pkg::KIND_TS:   flags_next[tops_pkg::FL_TS]   = 1'b1;
        default: ;
      endcase
      phase_next = PH_KIND;
      list_it    = 1'b1;
      list_kind  = cur_kind;
    end

    if (list_it && count < tops_pkg::CNT_W'(tops_pkg::MAX_KINDS)) begin
      if (count < tops_pkg::CNT_W'(tops_pkg::KEEP_KINDS)) begin
        kinds_next[count[tops_pkg::KIDX_W-1:0]] = list_kind;
      end
      count_next = count + 1'b1;
    end
  end

  always_comb begin
    verdict = tops_pkg::VERDICT_NONE;
    if (count_next >= tops_pkg::CNT_W'(3) && kinds_next[0] == tops_pkg::KIND_MSS) begin
      if (count_next >= tops_pkg::CNT_W'(4) && kinds_next[1] == tops_pkg::KIND_NOP &&
          kinds_next[2] == tops_pkg::KIND_NOP && kinds_next[3] == tops_pkg::KIND_SACK) begin
        verdict = tops_pkg::VERDICT_MSS_NOP;
      end else if (kinds_next[1] == tops_pkg::KIND_SACK &&
                   kinds_next[2] == tops_pkg::KIND_WS) begin
        verdict = tops_pkg::VERDICT_MSS_SACK;
      end
    end

    res_next.verdict       = verdict;
    res_next.option_count  = 4'(count_next);
    res_next.has_mss       = flags_next[tops_pkg::FL_MSS];
    res_next.mss_size      = flags_next[tops_pkg::FL_MSS] ? seg_next : 16'd0;
    res_next.has_wscale    = flags_next[tops_pkg::FL_WS];
    res_next.wscale_value  = flags_next[tops_pkg::FL_WS] ? scale_next : 8'd0;
    res_next.has_sack_perm = flags_next[tops_pkg::FL_SACK];
    res_next.has_timestamp = flags_next[tops_pkg::FL_TS];
    res_next.has_noop      = flags_next[tops_pkg::FL_NOP];
    res_next.first_kind    = kinds_next[0];
    res_next.second_kind   = kinds_next[1];
    res_next.third_kind    = kinds_next[2];
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      result <= res_next;
    end
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= PH_KIND;
      stopped   <= 1'b0;
      cur_kind  <= '0;
      rec_len   <= '0;
      body_pos  <= '0;
      pend      <= '0;
      seg       <= '0;
      scale     <= '0;
      flags     <= '0;
      count     <= '0;
      area      <= '0;
      for (int i = 0; i < tops_pkg::KEEP_KINDS; i++) begin
        kinds[i] <= '0;
      end
    end else begin
      if (pop && head.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (head.last) begin
          // header done, start clean for the next one
          phase    <= PH_KIND;
          stopped  <= 1'b0;
          cur_kind <= '0;
          rec_len  <= '0;
          body_pos <= '0;
          pend     <= '0;
          seg      <= '0;
          scale    <= '0;
          flags    <= '0;
          count    <= '0;
          area     <= '0;
          for (int i = 0; i < tops_pkg::KEEP_KINDS; i++) begin
            kinds[i] <= '0;
          end
        end else begin
          phase    <= phase_next;
          stopped  <= stopped_next;
          cur_kind <= cur_kind_next;
          rec_len  <= rec_len_next;
          body_pos <= body_pos_next;
          pend     <= pend_next;
          seg      <= seg_next;
          scale    <= scale_next;
          flags    <= flags_next;
          count    <= count_next;
          area     <= area_next;
          kinds    <= kinds_next;
        end
      end
    end
  end

endmodule

// File: rtl/tcp_option_parser_signature.sv
// channel  handshake            payload
// in       in_valid/in_ready    opt_byte, byte_valid, last_byte
// out      out_valid/out_ready  verdict, option_count, has_*, mss_size, wscale_value,
//                               first_kind, second_kind, third_kind
//
// one request per cycle when not stalled; a four-entry queue sits between the
// classifier and the parser; the parser takes one queued request each unstalled cycle
// a header's last request waits in the queue, then its result goes to the output
// register; in_ready drops only when the queue is full
// a waiting result stalls the parser only at the next last request
// rst is synchronous and clears the queue, the parse state and the output valid
module tcp_option_parser_signature (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  opt_byte,
  input  logic        byte_valid,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  verdict,
  output logic [3:0]  option_count,
  output logic        has_mss,
  output logic [15:0] mss_size,
  output logic        has_wscale,
  output logic [7:0]  wscale_value,
  output logic        has_sack_perm,
  output logic        has_timestamp,
  output logic        has_noop,
  output logic [7:0]  first_kind,
  output logic [7:0]  second_kind,
  output logic [7:0]  third_kind
);

  tops_pkg::item_t         head;
  tops_pkg::queue_status_t qstat;
  tops_pkg::result_t       result;
  logic                    pop;

  tops_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opt_byte   (opt_byte),
    .byte_valid (byte_valid),
    .last_byte  (last_byte),
    .pop        (pop),
    .head       (head),
    .status     (qstat)
  );

  tops_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (qstat.head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result     (result)
  );

  assign verdict       = result.verdict;
  assign option_count  = result.option_count;
  assign has_mss       = result.has_mss;
  assign mss_size      = result.mss_size;
  assign has_wscale    = result.has_wscale;
  assign wscale_value  = result.wscale_value;
  assign has_sack_perm = result.has_sack_perm;
  assign has_timestamp = result.has_timestamp;
  assign has_noop      = result.has_noop;
  assign first_kind    = result.first_kind;
  assign second_kind   = result.second_kind;
  assign third_kind    = result.third_kind;

`ifndef SYNTHESIS
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pop && head.last))
    else $error("result appeared without a last request");

  a_queue_fill: assert property (@(posedge clk) disable iff (rst)
    (qstat.push && !pop) |=> (qstat.count == $past(qstat.count) + 1'b1))
    else $error("queue count lost a request");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> qstat.head_valid)
    else $error("parser took a request from an empty queue");

  a_last_waits: assert property (@(posedge clk) disable iff (rst)
    (qstat.head_valid && head.last && out_valid && !out_ready) |-> !pop)
    else $error("last request overwrote a waiting result");
`endif

endmodule
